### hdl/wav_hp_pkg.sv
// ----------------------------------------------------------------------------
// wav_hp_pkg
// Shared types and constants for the WAV header parser.
// ----------------------------------------------------------------------------
package wav_hp_pkg;

  // Tags, as assembled little-endian from four bytes
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [15:0] PCM_CODE = 16'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOT_WAV = 3'd1,
    ST_NON_PCM = 3'd2,
    ST_NO_FMT  = 3'd3,
    ST_NO_DATA = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    PH_RIFF  = 8'b0000_0001,
    PH_RSIZE = 8'b0000_0010,
    PH_WAVE  = 8'b0000_0100,
    PH_ID    = 8'b0000_1000,
    PH_SIZE  = 8'b0001_0000,
    PH_FMT   = 8'b0010_0000,
    PH_SKIP  = 8'b0100_0000,
    PH_IDLE  = 8'b1000_0000
  } phase_t;

endpackage

### hdl/wav_hp_in_if.sv
// ----------------------------------------------------------------------------
// wav_hp_in_if
// Byte stream channel into the WAV header parser.
// ----------------------------------------------------------------------------
interface wav_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_file;

  modport source (output valid, output byte_value, output end_of_file, input ready);
  modport sink   (input valid, input byte_value, input end_of_file, output ready);
endinterface

### hdl/wav_hp_out_if.sv
// ----------------------------------------------------------------------------
// wav_hp_out_if
// Result channel out of the WAV header parser.
// ----------------------------------------------------------------------------
interface wav_hp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] num_channels;
  logic [31:0] sample_rate;
  logic [15:0] bits_per_sample;
  logic [31:0] data_size;
  logic [31:0] data_offset;

  modport source (output valid, output status, output num_channels, output sample_rate,
                  output bits_per_sample, output data_size, output data_offset,
                  input ready);
  modport sink   (input valid, input status, input num_channels, input sample_rate,
                  input bits_per_sample, input data_size, input data_offset,
                  output ready);
endinterface

### hdl/wav_header_parser_top.sv
// A result is on the output register in the cycle after the beat that causes it.
// Throughput: one byte beat per cycle unless stalled; the parse state updates once per beat.
// A pending result holds only while the output register is full and not being taken.
// Reset (rst_n low, synchronous) returns the parser to the RIFF tag and clears the result valid flag.
// Every end-of-file beat also returns all parse state to its reset values.
// ----------------------------------------------------------------------------
// wav_header_parser_top
// Byte-serial RIFF/WAVE header parser: checks tags, walks chunks, captures the
// PCM fmt fields and reports the data chunk size and offset.
// ----------------------------------------------------------------------------
module wav_header_parser_top
  import wav_hp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  wav_hp_in_if.sink     in_if,
  wav_hp_out_if.source  out_if
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] width_r, width_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic [15:0] out_chan_r;
  logic [31:0] out_rate_r;
  logic [15:0] out_width_r;
  logic [31:0] out_dsize_r;
  logic [31:0] out_doff_r;

  logic        in_acc;
  logic        emit;
  status_t     status;
  logic [31:0] dsize, doff;
  logic        keep;
  logic [1:0]  cnt2;
  logic [32:0] skip_dec;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    phase_nxt    = phase_r;
    fbc_nxt      = fbc_r;
    asm_nxt      = asm_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    skip_nxt     = skip_r;
    pos_nxt      = pos_r + 32'd1;
    fmt_seen_nxt = fmt_seen_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    width_nxt    = width_r;
    emit         = 1'b0;
    status       = ST_OK;
    dsize        = '0;
    doff         = '0;
    cnt2         = fbc_r[1:0];
    skip_dec     = skip_r;

    case (phase_r)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
        if (cnt2 == 2'd0) begin
          asm_nxt = {24'd0, in_if.byte_value};
        end else begin
          asm_nxt = asm_r | ({24'd0, in_if.byte_value} << {cnt2, 3'b000});
        end
        fbc_nxt = {2'b00, cnt2 + 2'd1};
        if (cnt2 == 2'd3) begin
          case (phase_r)
            PH_RIFF: begin
              if (asm_nxt == TAG_RIFF) begin
                phase_nxt = PH_RSIZE;
              end else begin
                emit   = 1'b1;
                status = ST_NOT_WAV;
              end
            end
            PH_RSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (asm_nxt == TAG_WAVE) begin
                phase_nxt = PH_ID;
              end else begin
                emit   = 1'b1;
                status = ST_NOT_WAV;
              end
            end
            PH_ID: begin
              id_nxt    = asm_nxt;
              phase_nxt = PH_SIZE;
            end
            default: begin
              len_nxt = asm_nxt;
              if (id_r == TAG_FMT) begin
                phase_nxt = PH_FMT;
              end else if (id_r == TAG_DATA) begin
                emit = 1'b1;
                if (fmt_seen_r) begin
                  status = ST_OK;
                  dsize  = asm_nxt;
                  doff   = pos_nxt;
                end else begin
                  status = ST_NO_FMT;
                end
              end else begin
                // odd-sized chunks carry one pad byte
                skip_nxt  = {1'b0, asm_nxt} + {32'd0, asm_nxt[0]};
                phase_nxt = (asm_nxt == 32'd0) ? PH_ID : PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_FMT: begin
        case (fbc_r)
          4'd0: asm_nxt = {24'd0, in_if.byte_value};
          4'd1: begin
            if ((asm_r | {16'd0, in_if.byte_value, 8'd0}) != {16'd0, PCM_CODE}) begin
              emit   = 1'b1;
              status = ST_NON_PCM;
            end
          end
          4'd2:  chan_nxt = {8'd0, in_if.byte_value};
          4'd3:  chan_nxt[15:8] = in_if.byte_value;
          4'd4:  rate_nxt = {24'd0, in_if.byte_value};
          4'd5:  rate_nxt[15:8] = in_if.byte_value;
          4'd6:  rate_nxt[23:16] = in_if.byte_value;
          4'd7:  rate_nxt[31:24] = in_if.byte_value;
          4'd14: width_nxt = {8'd0, in_if.byte_value};
          4'd15: width_nxt[15:8] = in_if.byte_value;
          default: ;
        endcase
        fbc_nxt = fbc_r + 4'd1;
        if (!emit && fbc_r == 4'd15) begin
          fmt_seen_nxt = 1'b1;
          // body is always 16 bytes; only a longer chunk has bytes to skip
          if (len_r > FMT_BODY) begin
            skip_nxt  = {1'b0, len_r - FMT_BODY};
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_ID;
          end
        end
      end
      PH_SKIP: begin
        if (skip_r != 33'd0) begin
          skip_dec = skip_r - 33'd1;
        end
        skip_nxt = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_nxt = PH_ID;
        end
      end
      default: ;
    endcase

    if (in_if.end_of_file && !emit && phase_nxt != PH_IDLE) begin
      emit = 1'b1;
      if (phase_nxt == PH_RIFF || phase_nxt == PH_RSIZE || phase_nxt == PH_WAVE) begin
        status = ST_NOT_WAV;
      end else begin
        status = fmt_seen_nxt ? ST_NO_DATA : ST_NO_FMT;
      end
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
    end

    keep = (status == ST_OK) || (status == ST_NO_DATA);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_if.end_of_file)) begin
      phase_r    <= PH_RIFF;
      fbc_r      <= '0;
      asm_r      <= '0;
      id_r       <= '0;
      len_r      <= '0;
      skip_r     <= '0;
      pos_r      <= '0;
      fmt_seen_r <= 1'b0;
      chan_r     <= '0;
      rate_r     <= '0;
      width_r    <= '0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      fbc_r      <= fbc_nxt;
      asm_r      <= asm_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      skip_r     <= skip_nxt;
      pos_r      <= pos_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      width_r    <= width_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_status_r <= status;
      out_chan_r   <= keep ? chan_nxt : 16'd0;
      out_rate_r   <= keep ? rate_nxt : 32'd0;
      out_width_r  <= keep ? width_nxt : 16'd0;
      out_dsize_r  <= dsize;
      out_doff_r   <= doff;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.num_channels    = out_chan_r;
  assign out_if.sample_rate     = out_rate_r;
  assign out_if.bits_per_sample = out_width_r;
  assign out_if.data_size       = out_dsize_r;
  assign out_if.data_offset     = out_doff_r;

  // An end-of-file beat always re-arms the parser.
  a_eof_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.end_of_file |=> phase_r == PH_RIFF && pos_r == 32'd0 && !fmt_seen_r)
    else $error("parser not re-armed after end of file");

  // A result beat with no end of file parks the parser in idle.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && !in_if.end_of_file |=> phase_r == PH_IDLE)
    else $error("parser not idle after result");

  // A full, stalled result register must block new bytes.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !in_if.ready)
    else $error("input taken while result stalled");

  // Data size and offset are only reported with an ok status.
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_dsize_r == 32'd0 && out_doff_r == 32'd0)
    else $error("data fields set on a non-ok result");

  // Tag and size fields are four bytes long.
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_FMT |-> fbc_r[3:2] == 2'b00)
    else $error("header byte count out of range");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Feeds whole WAV files, one byte beat at a time, into the parser: a table of
// hand-built files first (good headers, bad tags, non-PCM, missing chunks,
// truncated files), then random files and byte noise. A byte-level parser
// model predicts each header result; results are compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wav_hp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          RANDOM_BYTES = 900;
  localparam logic [31:0] BAD_RIFF     = 32'h5846_4952;  // "RIFX"
  localparam logic [31:0] BAD_WAVE     = 32'h5856_4157;  // "WAVX"
  localparam logic [31:0] NO_CUT       = 32'h4000_0000;

  typedef enum logic [1:0] {CK_NONE, CK_FMT, CK_OTHER, CK_DATA} chunk_kind_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } wav_result_t;

  // One file: tags, up to three chunks, fmt contents, optional truncation.
  // Rows with typed set carry their status; all other result fields are zero.
  typedef struct packed {
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    chunk_kind_t k0;
    chunk_kind_t k1;
    chunk_kind_t k2;
    logic [31:0] l0;
    logic [31:0] l1;
    logic [31:0] l2;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [15:0] cut;
    logic        typed;
    status_t     want;
  } file_case_t;

  localparam file_case_t DIR_CASES [19] = '{
    '{BAD_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd0, 1'b1, ST_NOT_WAV},
    '{TAG_RIFF, BAD_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd0, 1'b1, ST_NOT_WAV},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      16'd3, 16'd1, 16'd32, 32'd48000, 16'd0, 1'b1, ST_NON_PCM},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      16'h0101, 16'd1, 16'd8, 32'd8000, 16'd0, 1'b1, ST_NON_PCM},
    '{TAG_RIFF, TAG_WAVE, CK_DATA, CK_FMT, CK_NONE, 12, 16, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd22050, 16'd0, 1'b1, ST_NO_FMT},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_OTHER, CK_NONE, 16, 5, 0,
      PCM_CODE, 16'd6, 16'd24, 32'd96000, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 4, 0, 0,
      PCM_CODE, 16'd1, 16'd12, 32'd11025, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_OTHER, CK_DATA, 19, 0, 3,
      PCM_CODE, 16'd4, 16'd20, 32'd32000, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_FMT, CK_DATA, 16, 18, 2,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_OTHER, CK_FMT, CK_DATA, 1, 16, 32'hFFFF_FFFF,
      PCM_CODE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 0, 0,
      PCM_CODE, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd1, 1'b1, ST_NOT_WAV},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd6, 1'b1, ST_NOT_WAV},
    '{BAD_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd4, 1'b1, ST_NOT_WAV},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd25, 1'b1, ST_NO_FMT},
    '{TAG_RIFF, TAG_WAVE, CK_OTHER, CK_NONE, CK_NONE, 32'hFFFF_FFFF, 0, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd30, 1'b1, ST_NO_FMT},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_OTHER, CK_NONE, 16, 32'hFFFF_FFFF, 0,
      PCM_CODE, 16'd3, 16'd8, 32'd16000, 16'd50, 1'b0, ST_OK},
    '{TAG_RIFF, TAG_WAVE, CK_FMT, CK_DATA, CK_NONE, 16, 8, 0,
      PCM_CODE, 16'd2, 16'd16, 32'd44100, 16'd12, 1'b0, ST_OK}
  };

  logic clk;
  logic rst_n;

  wav_hp_in_if  in_ch ();
  wav_hp_out_if out_ch ();

  wav_header_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  wav_result_t expected_headers [$];
  logic [7:0]  file_q [$];
  int unsigned build_cap;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          fail_count;
  int          beats_sent;
  int unsigned cycle_count;
  bit          typed_mode;
  wav_result_t typed_result;
  wav_result_t oldest_header;

  // Parser model state
  phase_t      hp_phase;
  logic [4:0]  hp_count;
  logic [31:0] hp_word;
  logic [31:0] hp_id;
  logic [31:0] hp_len;
  logic [32:0] hp_skip;
  logic [31:0] hp_pos;
  logic        hp_fmt_seen;
  logic [15:0] hp_chan;
  logic [31:0] hp_rate;
  logic [15:0] hp_bits;

  function automatic void hp_reset();
    hp_phase    = PH_RIFF;
    hp_count    = '0;
    hp_word     = '0;
    hp_id       = '0;
    hp_len      = '0;
    hp_skip     = '0;
    hp_pos      = '0;
    hp_fmt_seen = 1'b0;
    hp_chan     = '0;
    hp_rate     = '0;
    hp_bits     = '0;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a header result.
  function automatic bit parse_byte(input logic [7:0] b, input logic eof,
                                    output wav_result_t res);
    bit          emit;
    bit          keep;
    status_t     st;
    logic [31:0] dsize;
    logic [31:0] doff;
    logic [3:0]  cnt;
    emit  = 1'b0;
    st    = ST_OK;
    dsize = '0;
    doff  = '0;
    res   = '0;
    hp_pos = hp_pos + 32'd1;
    case (hp_phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
        cnt = {2'b00, hp_count[1:0]};
        if (cnt == 4'd0) begin
          hp_word = {24'd0, b};
        end else begin
          hp_word = hp_word | (32'(b) << (8 * cnt));
        end
        hp_count = {3'b000, cnt[1:0] + 2'd1};
        if (cnt == 4'd3) begin
          case (hp_phase)
            PH_RIFF: begin
              if (hp_word == TAG_RIFF) begin
                hp_phase = PH_RSIZE;
              end else begin
                emit = 1'b1;
                st   = ST_NOT_WAV;
              end
            end
            PH_RSIZE: hp_phase = PH_WAVE;
            PH_WAVE: begin
              if (hp_word == TAG_WAVE) begin
                hp_phase = PH_ID;
              end else begin
                emit = 1'b1;
                st   = ST_NOT_WAV;
              end
            end
            PH_ID: begin
              hp_id    = hp_word;
              hp_phase = PH_SIZE;
            end
            default: begin
              hp_len = hp_word;
              if (hp_id == TAG_FMT) begin
                hp_phase = PH_FMT;
              end else if (hp_id == TAG_DATA) begin
                emit = 1'b1;
                if (hp_fmt_seen) begin
                  st    = ST_OK;
                  dsize = hp_len;
                  doff  = hp_pos;
                end else begin
                  st = ST_NO_FMT;
                end
              end else begin
                // odd-sized chunks carry one pad byte
                hp_skip  = {1'b0, hp_len} + 33'(hp_len[0]);
                hp_phase = (hp_skip == '0) ? PH_ID : PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_FMT: begin
        cnt = hp_count[3:0];
        case (cnt)
          4'd0: hp_word = {24'd0, b};
          4'd1: begin
            if ({b, hp_word[7:0]} != PCM_CODE) begin
              emit = 1'b1;
              st   = ST_NON_PCM;
            end
          end
          4'd2: hp_chan = {8'd0, b};
          4'd3: hp_chan[15:8] = b;
          4'd4: hp_rate = {24'd0, b};
          4'd5, 4'd6, 4'd7: hp_rate = hp_rate | (32'(b) << (8 * (cnt - 4)));
          4'd14: hp_bits = {8'd0, b};
          4'd15: hp_bits[15:8] = b;
          default: ;
        endcase
        hp_count = {1'b0, cnt + 4'd1};
        // body is always 16 bytes; only a longer size leaves bytes to skip
        if (!emit && cnt == 4'd15) begin
          hp_fmt_seen = 1'b1;
          if (hp_len > FMT_BODY) begin
            hp_skip  = {1'b0, hp_len - FMT_BODY};
            hp_phase = PH_SKIP;
          end else begin
            hp_phase = PH_ID;
          end
        end
      end
      PH_SKIP: begin
        if (hp_skip != '0) hp_skip = hp_skip - 33'd1;
        if (hp_skip == '0) hp_phase = PH_ID;
      end
      default: ;
    endcase

    if (eof && !emit && hp_phase != PH_IDLE) begin
      emit = 1'b1;
      if (hp_phase inside {PH_RIFF, PH_RSIZE, PH_WAVE}) begin
        st = ST_NOT_WAV;
      end else begin
        st = hp_fmt_seen ? ST_NO_DATA : ST_NO_FMT;
      end
    end

    if (emit) begin
      keep                = (st == ST_OK) || (st == ST_NO_DATA);
      res.status          = st;
      res.num_channels    = keep ? hp_chan : '0;
      res.sample_rate     = keep ? hp_rate : '0;
      res.bits_per_sample = keep ? hp_bits : '0;
      res.data_size       = dsize;
      res.data_offset     = doff;
      hp_phase            = PH_IDLE;
    end
    if (eof) hp_reset();
    return emit;
  endfunction

  // File assembly
  function automatic void put_byte(input logic [7:0] b);
    if (file_q.size() < build_cap) file_q.push_back(b);
  endfunction

  function automatic void put_half(input logic [15:0] h);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    put_half(w[15:0]);
    put_half(w[31:16]);
  endfunction

  function automatic void put_noise(input longint n);
    for (longint j = 0; j < n && file_q.size() < build_cap; j++) put_byte(8'($urandom));
  endfunction

  function automatic logic [31:0] other_id();
    logic [31:0] id;
    do id = $urandom; while (id == TAG_FMT || id == TAG_DATA);
    return id;
  endfunction

  function automatic void build_file(input file_case_t fc);
    chunk_kind_t kinds [3];
    logic [31:0] lens [3];
    int          n_fmt;
    logic [15:0] code;
    logic [15:0] ch;
    logic [15:0] bw;
    logic [31:0] sr;
    file_q.delete();
    build_cap = (fc.cut != 0) ? 32'(fc.cut) : NO_CUT;
    kinds = '{fc.k0, fc.k1, fc.k2};
    lens  = '{fc.l0, fc.l1, fc.l2};
    n_fmt = 0;
    put_word(fc.riff_tag);
    put_word($urandom);
    put_word(fc.wave_tag);
    for (int i = 0; i < 3; i++) begin
      case (kinds[i])
        CK_FMT: begin
          // a repeated fmt chunk gets fresh contents so the overwrite shows
          if (n_fmt == 0) begin
            code = fc.fmt_code;
            ch   = fc.chans;
            sr   = fc.rate;
            bw   = fc.bits;
          end else begin
            code = PCM_CODE;
            ch   = 16'($urandom);
            sr   = $urandom;
            bw   = 16'($urandom);
          end
          n_fmt++;
          put_word(TAG_FMT);
          put_word(lens[i]);
          put_half(code);
          put_half(ch);
          put_word(sr);
          put_word($urandom);
          put_half(16'($urandom));
          put_half(bw);
          if (lens[i] > FMT_BODY) put_noise(longint'(lens[i] - FMT_BODY));
        end
        CK_OTHER: begin
          put_word(other_id());
          put_word(lens[i]);
          put_noise(longint'(lens[i]) + longint'(lens[i][0]));
        end
        CK_DATA: begin
          put_word(TAG_DATA);
          put_word(lens[i]);
          put_noise(longint'($urandom_range(0, 3)));
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void build_noise();
    file_q.delete();
    build_cap = NO_CUT;
    if ($urandom_range(1) == 1) put_word(TAG_RIFF);
    put_noise(longint'($urandom_range(1, 12)));
  endfunction

  function automatic logic [31:0] random_len(input chunk_kind_t k);
    int r;
    r = $urandom_range(99);
    case (k)
      CK_FMT:   return (r < 60) ? 32'd16 : (r < 75) ? 32'($urandom_range(0, 15))
                                                     : 32'($urandom_range(17, 24));
      CK_OTHER: return 32'($urandom_range(0, 9));
      CK_DATA:  return (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFF_FFFF : 32'($urandom);
      default:  return 32'd0;
    endcase
  endfunction

  function automatic file_case_t random_case();
    file_case_t fc;
    int         r;
    fc = '0;
    fc.riff_tag = TAG_RIFF;
    fc.wave_tag = TAG_WAVE;
    r = $urandom_range(99);
    if (r < 6) begin
      fc.riff_tag = fc.riff_tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    end else if (r < 12) begin
      fc.wave_tag = fc.wave_tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    end
    fc.fmt_code = ($urandom_range(9) == 0) ? 16'($urandom) : PCM_CODE;
    fc.chans    = 16'($urandom);
    fc.rate     = $urandom;
    fc.bits     = 16'($urandom);
    r = $urandom_range(99);
    fc.k0 = (r < 60) ? CK_FMT : (r < 90) ? CK_OTHER : CK_DATA;
    r = $urandom_range(99);
    fc.k1 = (r < 60) ? CK_DATA : (r < 70) ? CK_FMT : (r < 90) ? CK_OTHER : CK_NONE;
    r = $urandom_range(99);
    fc.k2 = (r < 70) ? CK_DATA : (r < 85) ? CK_NONE : (r < 93) ? CK_FMT : CK_OTHER;
    fc.l0 = random_len(fc.k0);
    fc.l1 = random_len(fc.k1);
    fc.l2 = random_len(fc.k2);
    fc.cut = ($urandom_range(99) < 12) ? 16'($urandom_range(1, 60)) : 16'd0;
    return fc;
  endfunction

  // Byte beats
  task automatic send_beat(input logic [7:0] b, input logic eof);
    wav_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.byte_value  <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (parse_byte(b, eof, res)) expected_headers.push_back(typed_mode ? typed_result : res);
    beats_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_beat(file_q[i], i == file_q.size() - 1);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_headers.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_ch.status);
        fail_count++;
      end else begin
        oldest_header = expected_headers.pop_front();
        check_field("status", 32'(oldest_header.status), 32'(out_ch.status));
        check_field("num_channels", 32'(oldest_header.num_channels), 32'(out_ch.num_channels));
        check_field("sample_rate", oldest_header.sample_rate, out_ch.sample_rate);
        check_field("bits_per_sample", 32'(oldest_header.bits_per_sample),
                    32'(out_ch.bits_per_sample));
        check_field("data_size", oldest_header.data_size, out_ch.data_size);
        check_field("data_offset", oldest_header.data_offset, out_ch.data_offset);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int rand_start;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.byte_value  <= '0;
    in_ch.end_of_file <= 1'b0;
    tx_idle_pct = 19;
    rx_idle_pct = 84;
    fail_count  = 0;
    beats_sent  = 0;
    cycle_count = 0;
    typed_mode  = 1'b0;
    hp_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_CASES[i]) begin
      typed_mode          = DIR_CASES[i].typed;
      typed_result        = '0;
      typed_result.status = DIR_CASES[i].want;
      build_file(DIR_CASES[i]);
      send_file();
    end
    typed_mode = 1'b0;

    rand_start = beats_sent;
    while (beats_sent - rand_start < RANDOM_BYTES) begin
      if (beats_sent - rand_start < RANDOM_BYTES / 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 84;
      end else if (beats_sent - rand_start < 2 * RANDOM_BYTES / 3) begin
        tx_idle_pct = 84;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        build_noise();
      end else begin
        build_file(random_case());
      end
      send_file();
    end
    in_ch.valid <= 1'b0;

    while (expected_headers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
